// ----- hw/rtl/dpfmod_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpfmod_pkg: shared types and constants for the double fmod block
// Holds the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dpfmod_pkg;

  localparam logic [63:0] QnanBits  = 64'h7FF8_0000_0000_0000;
  localparam logic [10:0] ExpAllOnes = 11'h7FF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_DIV,
    ST_RENORM,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture operands and classify
    logic norm_step; // shift subnormal significands one place
    logic div_step;  // one restoring step
    logic div_last;  // final subtract, no shift
    logic ren_step;  // one renormalize shift
    logic pack;      // form the result word
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic early;     // result known at load (special cases)
    logic norm_done; // both significands have leading one at bit 52
    logic n_zero;    // exponent difference exhausted
    logic ren_done;  // renormalization finished
  } dp_stat_t;

endpackage : dpfmod_pkg
`default_nettype wire

// ----- hw/rtl/dpfmod_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpfmod_ctrl: sequencer for the double fmod block
// Steps the datapath through normalize, divide, renormalize and pack.
// ----------------------------------------------------------------------------
module dpfmod_ctrl
  import dpfmod_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire logic     out_free,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done
);

  state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if (stat.early) state_next = ST_DONE;
        else if (stat.norm_done) state_next = ST_DIV;
        else cmd.norm_step = 1'b1;
      end
      ST_DIV: begin
        if (stat.n_zero) begin
          cmd.div_last = 1'b1;
          state_next   = ST_RENORM;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_RENORM: begin
        if (stat.ren_done) begin
          cmd.pack   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.ren_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A done pulse only leaves the final state
  assert property (@(posedge clk) disable iff (rst) done |-> state == ST_DONE)
    else $error("done outside final state");
  // A load is only issued from idle and always leads into normalize
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == ST_NORM)
    else $error("load did not enter normalize");
  // Divide steps stop once the difference is used up
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && stat.n_zero) |=> state == ST_RENORM)
    else $error("divide overran");

endmodule : dpfmod_ctrl
`default_nettype wire

// ----- hw/rtl/dpfmod_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dpfmod_dp: datapath for the double fmod block
// Classifies operands, normalizes, runs shift-subtract and packs the result.
// ----------------------------------------------------------------------------
module dpfmod_dp
  import dpfmod_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [63:0] x_in,
  input  wire logic [63:0] y_in,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output logic [63:0]      res,
  output logic             inv
);

  logic        sx;
  logic        early;
  logic [53:0] mx;
  logic [52:0] my;
  logic signed [12:0] e1, e2;
  logic [11:0] n;

  logic [62:0] ax, ay;
  logic [10:0] ex, ey;
  logic        inv_c;
  logic [54:0] diff;
  logic [53:0] rsub;
  logic [11:0] sh;
  logic [52:0] rs;

  assign ax    = x_in[62:0];
  assign ay    = y_in[62:0];
  assign ex    = ax[62:52];
  assign ey    = ay[62:52];
  assign inv_c = (ex == ExpAllOnes) || ((ey == ExpAllOnes) && (ay[51:0] != '0))
                 || (ay == '0);

  // Restoring subtract of the partial remainder
  assign diff = {1'b0, mx} - {2'b00, my};
  assign rsub = diff[54] ? mx : diff[53:0];

  // Load, normalize, divide, renormalize and pack
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx    <= x_in[63];
      inv   <= inv_c;
      early <= inv_c || (ax <= ay);
      if (inv_c) res <= QnanBits;
      else if (ax < ay) res <= x_in;
      else if (ax == ay) res <= {x_in[63], 63'd0};
      mx <= {1'b0, (ex != '0), ax[51:0]};
      my <= {(ey != '0), ay[51:0]};
      e1 <= (ex != '0) ? {2'b00, ex} : 13'sd1;
      e2 <= (ey != '0) ? {2'b00, ey} : 13'sd1;
    end
    if (cmd.norm_step) begin
      if (!mx[52]) begin
        mx <= {mx[52:0], 1'b0};
        e1 <= e1 - 13'sd1;
      end
      if (!my[52]) begin
        my <= {my[51:0], 1'b0};
        e2 <= e2 - 13'sd1;
      end
    end
    if (stat.norm_done && !early && !cmd.div_step && !cmd.div_last && !cmd.ren_step
        && !cmd.pack && !cmd.norm_step && !cmd.load)
      n <= 12'(e1 - e2);
    if (cmd.div_step) begin
      mx <= {rsub[52:0], 1'b0};
      n  <= n - 12'd1;
    end
    if (cmd.div_last) mx <= rsub;
    if (cmd.ren_step) begin
      mx <= {mx[52:0], 1'b0};
      e2 <= e2 - 13'sd1;
    end
    if (cmd.pack) begin
      if (mx == '0) res <= {sx, 63'd0};
      else if (e2 < 13'sd1) res <= {sx, 11'd0, rs[51:0]};
      else if (mx[52]) res <= {sx, e2[10:0], mx[51:0]};
      else res <= {sx, 11'd0, mx[51:0]};
    end
  end

  // Subnormal pack: e2 < 1 only after subnormal divisor, shift right 1-e2
  assign sh = 12'(13'sd1 - e2);
  assign rs = mx[52:0] >> sh;

  assign stat.early     = early;
  assign stat.norm_done = mx[52] && my[52];
  assign stat.n_zero    = (n == '0);
  assign stat.ren_done  = (mx == '0) || mx[52] || (e2 <= 13'sd1);

  // After the final subtract the remainder is below the divisor
  assert property (@(posedge clk) cmd.div_last |=> mx < {1'b0, my})
    else $error("remainder not reduced");
  // An invalid item always carries the quiet NaN
  assert property (@(posedge clk) (cmd.load && inv_c) |=> res == QnanBits)
    else $error("invalid without NaN");
  // Divisor stays normalized while dividing
  assert property (@(posedge clk) cmd.div_step |-> my[52])
    else $error("divisor not normalized");

endmodule : dpfmod_dp
`default_nettype wire

// ----- hw/rtl/double_precision_fmod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// double_precision_fmod: IEEE 754 double remainder x - trunc(x/y)*y
// Controller plus shift-subtract datapath, one quotient bit per cycle.
// ----------------------------------------------------------------------------
// One request at a time. Special cases (invalid, |x| <= |y|) go from load
// straight to the result without normalize, divide or renormalize steps.
// Otherwise a request takes normalize shifts, one divide step per bit of
// exponent difference plus a final subtract, renormalize shifts and a pack,
// where the exponent difference is taken after both significands are
// normalized and so reaches 2097 for the largest finite x over the smallest
// subnormal y, after 52 normalize shifts. The single restoring subtractor
// handles one bit of exponent difference each cycle, and the normalize and
// renormalize shifters one place each cycle. The result is held in an output
// register until taken, and a result that is not taken stalls the next one.
module double_precision_fmod
  import dpfmod_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // [63:0] dividend, [127:64] divisor
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata   // [63:0] remainder, [64] invalid, rest 0
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        busy, done, start, out_free;
  logic [63:0] res, x_q, y_q;
  logic        inv;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign x_q      = s_tdata[63:0];
  assign y_q      = s_tdata[127:64];

  dpfmod_ctrl u_ctrl (
    .clk, .rst, .start, .out_free, .stat, .cmd, .busy, .done
  );

  dpfmod_dp u_dp (
    .clk, .x_in(x_q), .y_in(y_q), .cmd, .stat, .res, .inv
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {7'd0, inv, res};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule : double_precision_fmod
`default_nettype wire
